// ===== hdl/sliding_window_median_macros.svh =====
// ----------------------------------------------------------------------------
// Sliding window median - assertion macros
// Shared concurrent assertion forms, clocked and reset-gated.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MEDIAN_MACROS_SVH
`define SLIDING_WINDOW_MEDIAN_MACROS_SVH

// same-cycle implication
`define SWM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("swm assertion failed");

// next-cycle implication
`define SWM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("swm assertion failed");

`endif

// ===== hdl/swm_pkg.sv =====
// ----------------------------------------------------------------------------
// Sliding window median - package
// Widths, cell types and control codes shared by the cell chain and top.
// ----------------------------------------------------------------------------
package swm_pkg;

    localparam int MAX_WINDOW = 64;
    localparam int SAMPLE_W   = 32;
    localparam int AGE_W      = $clog2(MAX_WINDOW);
    localparam int IDX_W      = $clog2(MAX_WINDOW);
    localparam int WS_W       = 7;
    localparam int OUT_W      = SAMPLE_W + 1;

    localparam logic [WS_W-1:0] WS_RESET = WS_W'(3);

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [OUT_W-1:0]    t_median;
    typedef logic [AGE_W-1:0]           t_age;
    typedef logic [WS_W-1:0]            t_wsize;

    typedef struct packed {
        logic    valid;
        t_sample value;
        t_age    age;
    } t_cell_data;

    typedef enum logic [1:0] {
        OP_HOLD    = 2'd0,
        OP_KILL    = 2'd1,
        OP_SQUEEZE = 2'd2,
        OP_INSERT  = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     restart;
        t_age     age_limit;
        t_sample  sample;
    } t_cell_ctrl;

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_SQUEEZE = 5'b00010,
        S_INSERT  = 5'b00100,
        S_PICK    = 5'b01000,
        S_EMIT    = 5'b10000
    } t_state;

endpackage

// ===== hdl/swm_in_if.sv =====
// ----------------------------------------------------------------------------
// Sliding window median - input channel
// Sample items with restart flag, valid/ready handshake.
// ----------------------------------------------------------------------------
interface swm_in_if;
    logic             valid;
    logic             ready;
    swm_pkg::t_sample sample;
    logic             restart;

    modport source (output valid, output sample, output restart, input ready);
    modport sink   (input valid, input sample, input restart, output ready);
endinterface

// ===== hdl/swm_out_if.sv =====
// ----------------------------------------------------------------------------
// Sliding window median - result channel
// Doubled median items, valid/ready handshake.
// ----------------------------------------------------------------------------
interface swm_out_if;
    logic             valid;
    logic             ready;
    swm_pkg::t_median median_doubled;

    modport source (output valid, output median_doubled, input ready);
    modport sink   (input valid, input median_doubled, output ready);
endinterface

// ===== hdl/swm_cfg_if.sv =====
// ----------------------------------------------------------------------------
// Sliding window median - configuration channel
// Window size register writes, valid/ready handshake.
// ----------------------------------------------------------------------------
interface swm_cfg_if;
    logic             valid;
    logic             ready;
    swm_pkg::t_wsize  window_size;

    modport source (output valid, output window_size, input ready);
    modport sink   (input valid, input window_size, output ready);
endinterface

// ===== hdl/sliding_window_median.sv =====
// ----------------------------------------------------------------------------
// Sliding window median - top level
// Running median over the last window_size samples, kept sorted in a cell
// chain with per-entry ages; gives twice the median once the window is full.
//
//   channel   | dir | payload
//   ----------+-----+------------------------------------
//   i_item    | in  | sample (s32), restart (1)
//   o_result  | out | median_doubled (s33)
//   i_cfg     | in  | window_size (u7), always ready
//
// Per item: accept/drop, one squeeze per dropped entry that sat below a kept
// entry (at most 1 once the window is full, more after a shrink, none on
// restart) and a final squeeze check, insert, pick, then emit only when it
// gives a result. The chain squeezes out one hole per cycle. Reset empties
// the chain and sets window_size to 3.
// A stalled result holds the block in emit; i_item.ready is low until idle.
// ----------------------------------------------------------------------------
`include "sliding_window_median_macros.svh"

module sliding_window_median (
    input  logic       i_clk,
    input  logic       i_rst_n,
    swm_in_if.sink     i_item,
    swm_out_if.source  o_result,
    swm_cfg_if.sink    i_cfg
);

    swm_pkg::t_state     r_state;
    swm_pkg::t_state     n_state;
    swm_pkg::t_wsize     r_window_size;
    swm_pkg::t_sample    r_sample;
    swm_pkg::t_sample    r_lo;
    swm_pkg::t_sample    r_hi;
    logic                r_out_valid;
    swm_pkg::t_median    r_out_data;
    swm_pkg::t_cell_ctrl w_ctrl;
    logic [swm_pkg::MAX_WINDOW-1:0] w_valid;
    logic [swm_pkg::MAX_WINDOW:0]   w_valid_ext;
    swm_pkg::t_sample    w_values [swm_pkg::MAX_WINDOW];
    swm_pkg::t_wsize     w_win;
    swm_pkg::t_age       w_age_limit;
    logic                w_contig;
    logic                w_full;
    logic [swm_pkg::IDX_W-1:0] w_idx_hi;
    logic [swm_pkg::IDX_W-1:0] w_idx_lo;
    logic                w_accept;
    logic                w_load;

    // window size: zero acts as 1, large values clamp
    always_comb begin
        w_win = r_window_size;
        if (r_window_size == '0) begin
            w_win = swm_pkg::WS_W'(1);
        end else if (r_window_size > swm_pkg::WS_W'(swm_pkg::MAX_WINDOW)) begin
            w_win = swm_pkg::WS_W'(swm_pkg::MAX_WINDOW);
        end
    end

    assign w_age_limit = swm_pkg::AGE_W'(w_win - swm_pkg::WS_W'(1));
    assign w_valid_ext = {1'b0, w_valid};
    assign w_contig    = ~|(~w_valid[swm_pkg::MAX_WINDOW-2:0] & w_valid[swm_pkg::MAX_WINDOW-1:1]);
    assign w_full      = w_valid[w_age_limit] && !w_valid_ext[w_win];
    assign w_idx_hi    = swm_pkg::IDX_W'(w_win >> 1);
    assign w_idx_lo    = w_win[0] ? w_idx_hi : w_idx_hi - swm_pkg::IDX_W'(1);

    assign i_item.ready   = (r_state == swm_pkg::S_IDLE);
    assign i_cfg.ready    = 1'b1;
    assign w_accept       = i_item.valid && i_item.ready;
    assign w_load         = (r_state == swm_pkg::S_EMIT) && (!r_out_valid || o_result.ready);
    assign o_result.valid = r_out_valid;
    assign o_result.median_doubled = r_out_data;

    always_comb begin
        w_ctrl.op        = swm_pkg::OP_HOLD;
        w_ctrl.restart   = i_item.restart;
        w_ctrl.age_limit = w_age_limit;
        w_ctrl.sample    = r_sample;
        case (r_state)
            swm_pkg::S_IDLE: begin
                if (w_accept) begin
                    w_ctrl.op = swm_pkg::OP_KILL;
                end
            end
            swm_pkg::S_SQUEEZE: begin
                if (!w_contig) begin
                    w_ctrl.op = swm_pkg::OP_SQUEEZE;
                end
            end
            swm_pkg::S_INSERT: begin
                w_ctrl.op = swm_pkg::OP_INSERT;
            end
            default: begin
                w_ctrl.op = swm_pkg::OP_HOLD;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            swm_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = swm_pkg::S_SQUEEZE;
                end
            end
            swm_pkg::S_SQUEEZE: begin
                if (w_contig) begin
                    n_state = swm_pkg::S_INSERT;
                end
            end
            swm_pkg::S_INSERT: begin
                n_state = swm_pkg::S_PICK;
            end
            swm_pkg::S_PICK: begin
                n_state = w_full ? swm_pkg::S_EMIT : swm_pkg::S_IDLE;
            end
            swm_pkg::S_EMIT: begin
                if (w_load) begin
                    n_state = swm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = swm_pkg::S_IDLE;
            end
        endcase
    end

    swm_chain u_chain (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_ctrl),
        .o_valid  (w_valid),
        .o_values (w_values)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= swm_pkg::S_IDLE;
            r_window_size <= swm_pkg::WS_RESET;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid && i_cfg.ready) begin
                r_window_size <= i_cfg.window_size;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sample <= i_item.sample;
        end
        if (r_state == swm_pkg::S_PICK) begin
            r_lo <= w_values[w_idx_lo];
            r_hi <= w_values[w_idx_hi];
        end
        if (w_load) begin
            r_out_data <= swm_pkg::t_median'(r_lo) + swm_pkg::t_median'(r_hi);
        end
    end

    `SWM_ASSERT_NEXT(a_accept_to_squeeze, i_clk, i_rst_n, w_accept, r_state == swm_pkg::S_SQUEEZE)
    `SWM_ASSERT_NOW(a_insert_packed, i_clk, i_rst_n, r_state == swm_pkg::S_INSERT, w_contig && !w_valid[swm_pkg::MAX_WINDOW-1])
    `SWM_ASSERT_NOW(a_pick_packed, i_clk, i_rst_n, r_state == swm_pkg::S_PICK, w_contig && w_valid[0])
    `SWM_ASSERT_NEXT(a_emit_stall, i_clk, i_rst_n, (r_state == swm_pkg::S_EMIT) && r_out_valid && !o_result.ready, r_state == swm_pkg::S_EMIT)

endmodule

// ===== hdl/swm_cell.sv =====
// ----------------------------------------------------------------------------
// Sliding window median - sorted cell
// Holds one window entry; drops, squeezes down, or shifts up on insert.
// ----------------------------------------------------------------------------
module swm_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  swm_pkg::t_cell_ctrl i_ctrl,
    input  swm_pkg::t_cell_data i_lower,
    input  swm_pkg::t_cell_data i_upper,
    input  logic                i_hole,
    input  logic                i_place,
    output swm_pkg::t_cell_data o_data,
    output logic                o_hole,
    output logic                o_place
);

    logic             r_valid;
    logic             n_valid;
    swm_pkg::t_sample r_value;
    swm_pkg::t_sample n_value;
    swm_pkg::t_age    r_age;
    swm_pkg::t_age    n_age;
    logic             w_place;

    // sorted ascending: place goes high at first entry greater than the sample
    assign w_place = !r_valid || (r_value > i_ctrl.sample);
    assign o_place = w_place;
    assign o_hole  = i_hole || !r_valid;
    assign o_data  = '{valid: r_valid, value: r_value, age: r_age};

    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        n_age   = r_age;
        case (i_ctrl.op)
            swm_pkg::OP_KILL: begin
                n_valid = r_valid && !i_ctrl.restart && (r_age < i_ctrl.age_limit);
            end
            swm_pkg::OP_SQUEEZE: begin
                if (i_hole || !r_valid) begin
                    n_valid = i_upper.valid;
                    n_value = i_upper.value;
                    n_age   = i_upper.age;
                end
            end
            swm_pkg::OP_INSERT: begin
                if (i_place) begin
                    n_valid = i_lower.valid;
                    n_value = i_lower.value;
                    n_age   = i_lower.age + swm_pkg::AGE_W'(1);
                end else if (w_place) begin
                    n_valid = 1'b1;
                    n_value = i_ctrl.sample;
                    n_age   = '0;
                end else begin
                    n_age   = r_age + swm_pkg::AGE_W'(1);
                end
            end
            default: begin
                n_valid = r_valid;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_age   <= n_age;
    end

endmodule

// ===== hdl/swm_chain.sv =====
// ----------------------------------------------------------------------------
// Sliding window median - cell chain
// Row of sorted cells linked to both neighbors, with hole and place chains.
// ----------------------------------------------------------------------------
module swm_chain (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  swm_pkg::t_cell_ctrl   i_ctrl,
    output logic [swm_pkg::MAX_WINDOW-1:0] o_valid,
    output swm_pkg::t_sample      o_values [swm_pkg::MAX_WINDOW]
);

    swm_pkg::t_cell_data w_data  [swm_pkg::MAX_WINDOW];
    logic                w_hole  [swm_pkg::MAX_WINDOW];
    logic                w_place [swm_pkg::MAX_WINDOW];

    assign w_hole[0]  = 1'b0;
    assign w_place[0] = 1'b0;

    for (genvar i = 0; i < swm_pkg::MAX_WINDOW; i++) begin : g_cell
        swm_pkg::t_cell_data w_lower;
        swm_pkg::t_cell_data w_upper;

        if (i == 0) begin : g_bottom
            assign w_lower = '0;
        end else begin : g_lower
            assign w_lower = w_data[i-1];
        end

        if (i == swm_pkg::MAX_WINDOW - 1) begin : g_top
            assign w_upper = '0;
            swm_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctrl  (i_ctrl),
                .i_lower (w_lower),
                .i_upper (w_upper),
                .i_hole  (w_hole[i]),
                .i_place (w_place[i]),
                .o_data  (w_data[i]),
                .o_hole  (),
                .o_place ()
            );
        end else begin : g_mid
            assign w_upper = w_data[i+1];
            swm_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctrl  (i_ctrl),
                .i_lower (w_lower),
                .i_upper (w_upper),
                .i_hole  (w_hole[i]),
                .i_place (w_place[i]),
                .o_data  (w_data[i]),
                .o_hole  (w_hole[i+1]),
                .o_place (w_place[i+1])
            );
        end

        assign o_valid[i]  = w_data[i].valid;
        assign o_values[i] = w_data[i].value;
    end

endmodule

// ===== sim/swm_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sliding window median - result checker
// Watches the item, result and window size channels, keeps its own sorted
// window with entry ages, and compares every result item with the doubled
// median it predicts. Reports the number of results still owed and failures.
// ----------------------------------------------------------------------------
module swm_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    swm_in_if    item_ch,
    swm_out_if   res_ch,
    swm_cfg_if   cfg_ch,
    output int   o_pending,
    output int   o_fail_count
);

    swm_pkg::t_sample win_vals [swm_pkg::MAX_WINDOW];
    int               win_ages [swm_pkg::MAX_WINDOW];
    int               win_fill;
    swm_pkg::t_wsize  win_size;
    swm_pkg::t_median median_q [$];

    // drop aged-out entries, insert the new sample after equal values,
    // queue twice the median once the window is full
    function automatic void push_sample(input swm_pkg::t_sample s, input logic clear);
        int w;
        int kept;
        int pos;
        int lo;
        int hi;
        logic [swm_pkg::OUT_W-1:0] sum;
        w = (win_size == '0) ? 1 :
            ((int'(win_size) > swm_pkg::MAX_WINDOW) ? swm_pkg::MAX_WINDOW : int'(win_size));
        if (clear) begin
            win_fill = 0;
        end
        kept = 0;
        for (int i = 0; i < win_fill; i++) begin
            if (win_ages[i] + 1 < w) begin
                win_vals[kept] = win_vals[i];
                win_ages[kept] = win_ages[i] + 1;
                kept++;
            end
        end
        win_fill = kept;
        pos = 0;
        while (pos < win_fill && win_vals[pos] <= s) begin
            pos++;
        end
        for (int i = win_fill; i > pos; i--) begin
            win_vals[i] = win_vals[i-1];
            win_ages[i] = win_ages[i-1];
        end
        win_vals[pos] = s;
        win_ages[pos] = 0;
        win_fill++;
        if (win_fill == w) begin
            hi = w / 2;
            lo = w[0] ? hi : hi - 1;
            sum = {win_vals[lo][swm_pkg::SAMPLE_W-1], win_vals[lo]}
                + {win_vals[hi][swm_pkg::SAMPLE_W-1], win_vals[hi]};
            median_q = {median_q, swm_pkg::t_median'(sum)};
        end
    endfunction

    initial begin
        o_pending    = 0;
        o_fail_count = 0;
        win_fill     = 0;
        win_size     = swm_pkg::WS_RESET;
    end

    always @(posedge i_clk) begin
        swm_pkg::t_median exp_median;
        if (!i_rst_n) begin
            win_fill = 0;
            win_size = swm_pkg::WS_RESET;
            median_q.delete();
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (median_q.size() == 0) begin
                    $error("unexpected result item: median_doubled %0d",
                           res_ch.median_doubled);
                    o_fail_count++;
                end else begin
                    exp_median = median_q.pop_front();
                    if (res_ch.median_doubled !== exp_median) begin
                        $error("median_doubled: expected %0d, actual %0d",
                               exp_median, res_ch.median_doubled);
                        o_fail_count++;
                    end
                end
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                win_size = cfg_ch.window_size;
            end
            if (item_ch.valid && item_ch.ready) begin
                push_sample(item_ch.sample, item_ch.restart);
            end
        end
        o_pending = median_q.size();
    end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sliding window median - testbench top
// Drives sample items and window size writes into the median filter, with
// directed extremes first and then random streams over many window sizes,
// under several sender idle and receiver stall mixes. Results are checked by
// a separate checker; the top gives the verdict.
// ----------------------------------------------------------------------------
module testbench;

    localparam int               QUIET_LIMIT     = 2000;
    localparam int               DRAIN_CYCLES    = 80;
    localparam int               ITEMS_PER_PHASE = 142;
    localparam int               NUM_PHASES      = 12;
    localparam swm_pkg::t_sample S_MAX           = 32'sh7FFF_FFFF;
    localparam swm_pkg::t_sample S_MIN           = 32'sh8000_0000;

    // window sizes per random phase; no restart at a change, so some
    // changes shrink and some grow a live window
    localparam int PHASE_WSIZE [NUM_PHASES] = '{5, 64, 2, 127, 1, 9, 4, 0, 33, 3, 17, 64};

    logic clk;
    logic rst_n;
    int   pending;
    int   fail_count;
    int   idle_pct;
    int   stall_pct;
    int   quiet_cycles;

    swm_in_if  item_ch ();
    swm_out_if res_ch ();
    swm_cfg_if cfg_ch ();

    sliding_window_median dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_item   (item_ch),
        .o_result (res_ch),
        .i_cfg    (cfg_ch)
    );

    swm_checker median_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .item_ch      (item_ch),
        .res_ch       (res_ch),
        .cfg_ch       (cfg_ch),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial begin
        clk = 1'b0;
    end

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk) begin
        res_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk) begin
        if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic set_idling(input int mode);
        case (mode)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 87; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 87; end
            default: begin idle_pct = 23; stall_pct = 23; end
        endcase
    endtask

    task automatic send_item(input swm_pkg::t_sample s, input logic clear);
        while ($urandom_range(99) < idle_pct) begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid   <= 1'b1;
        item_ch.sample  <= s;
        item_ch.restart <= clear;
        @(posedge clk);
        while (!item_ch.ready) begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // stop sending until every owed result is back, then let the block settle
    task automatic drain_results(input int extra);
        item_ch.valid <= 1'b0;
        while (pending != 0) begin
            @(negedge clk);
        end
        repeat (extra) @(negedge clk);
    endtask

    task automatic write_window(input swm_pkg::t_wsize ws);
        drain_results(DRAIN_CYCLES);
        cfg_ch.valid       <= 1'b1;
        cfg_ch.window_size <= ws;
        @(posedge clk);
        while (!cfg_ch.ready) begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic swm_pkg::t_sample pick_sample();
        case ($urandom_range(3))
            0: return $signed($urandom_range(8)) - 4;
            1: return $urandom_range(1) ? S_MAX : S_MIN;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        rst_n              = 1'b0;
        item_ch.valid      = 1'b0;
        item_ch.sample     = '0;
        item_ch.restart    = 1'b0;
        res_ch.ready       = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.window_size = '0;
        quiet_cycles       = 0;
        set_idling(0);
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset window of 3: extremes, restart, equal values
        send_item(S_MAX, 1'b0);
        send_item(S_MAX, 1'b0);
        send_item(S_MAX, 1'b0);
        send_item(S_MIN, 1'b0);
        send_item(S_MIN, 1'b0);
        send_item(S_MIN, 1'b0);
        send_item(32'sd7, 1'b1);
        send_item(-32'sd7, 1'b0);
        send_item(32'sd7, 1'b0);

        // zero window acts as one
        write_window(swm_pkg::t_wsize'(0));
        send_item(S_MIN, 1'b0);
        send_item(S_MAX, 1'b0);
        send_item(-32'sd1, 1'b1);

        // even window sums the two middle entries
        write_window(swm_pkg::t_wsize'(2));
        send_item(S_MAX, 1'b0);
        send_item(S_MAX, 1'b0);
        send_item(S_MIN, 1'b0);
        send_item(-32'sd3, 1'b0);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_window(swm_pkg::t_wsize'(PHASE_WSIZE[ph]));
            set_idling(ph % 4);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                send_item(pick_sample(), $urandom_range(99) == 0);
            end
        end

        drain_results(DRAIN_CYCLES);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
